/* rtl/core/audio_ring_starvation_ledger_macros.svh */
// Assertion macros used by the starvation ledger accumulator.
`ifndef AUDIO_RING_STARVATION_LEDGER_MACROS_SVH
`define AUDIO_RING_STARVATION_LEDGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ARSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ARSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/arsl_pkg.sv */
// Types, constants and helper functions of the audio ring starvation ledger.
package arsl_pkg;

	localparam int CNT_W         = 32;
	localparam int OUT_W         = 32;
	localparam int TIME_W        = 64;
	localparam int NOW_W         = 63;
	localparam int MS_W          = 16;
	localparam int US_PER_MS     = 1000;
	localparam int US_W          = 26;
	localparam int CFG_IDX_W     = 1;

	// gap / 1000 is taken as (gap >> 3) / 125, one 15-bit digit per step
	localparam int DIV_PRE_SHIFT = 3;
	localparam int DIVISOR       = US_PER_MS >> DIV_PRE_SHIFT;
	localparam int DIV_W         = NOW_W - DIV_PRE_SHIFT;
	localparam int CHUNK_W       = 15;
	localparam int DIV_STEPS     = DIV_W / CHUNK_W;
	localparam int REM_W         = 7;
	localparam int STEP_W        = REM_W + CHUNK_W;
	localparam int DIV_K_SHIFT   = 29;
	localparam int DIV_K_W       = 23;
	localparam int unsigned DIV_K = (32'd1 << DIV_K_SHIFT) / DIVISOR;
	localparam int PROD_W        = STEP_W + DIV_K_W;

	typedef enum logic [2:0] {
		OP_FEED     = 3'd0,
		OP_WAIT     = 3'd1,
		OP_DRAIN    = 3'd2,
		OP_FLUSHED  = 3'd3,
		OP_QUERY    = 3'd4,
		OP_RESERVE  = 3'd5,
		OP_ROLLBACK = 3'd6
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW = 1'b1;

	typedef struct packed {
		logic              watching;
		logic              charge;
		logic [TIME_W-1:0] empty;
		logic [NOW_W-1:0]  now;
		logic [CNT_W-1:0]  events;
		logic [CNT_W-1:0]  written;
		logic [DIV_W-1:0]  dividend;
	} state_rec_t;

	typedef struct packed {
		logic             playing;
		logic             charge;
		logic [CNT_W-1:0] events;
		logic [CNT_W-1:0] written;
		logic [REM_W-1:0] rem;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] quot;
	} div_rec_t;

	function automatic logic [US_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
		return US_W'(ms) * US_W'(US_PER_MS);
	endfunction

	function automatic logic sgt(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] d);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, d};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

/* rtl/core/arsl_state.sv */
// Ledger state update: flags, predicted empty time and counters, one word per cycle unless out_ready stalls it.
module arsl_state import arsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MS_W-1:0]   ring_length_ms,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        opcode,
	input  logic [NOW_W-1:0]  now_us,
	input  logic [MS_W-1:0]   duration_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output state_rec_t        out_rec
);

	logic              watching_q, draining_q, stale_q;
	logic [TIME_W-1:0] empty_q;
	logic [CNT_W-1:0]  written_q, events_q;

	logic              watching_d, draining_d, stale_d, charge;
	logic [TIME_W-1:0] empty_d, now_ext, dur_us, ring_us, gap;
	logic [CNT_W-1:0]  written_d, events_d;

	logic              valid_s1;
	state_rec_t        rec_s1;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !valid_s1 || out_ready;
	assign now_ext  = {1'b0, now_us};
	assign dur_us   = TIME_W'(ms_to_us(duration_ms));
	assign ring_us  = TIME_W'(ms_to_us(ring_length_ms));
	assign gap      = now_ext - empty_q;

	always_comb begin
		watching_d = watching_q;
		draining_d = draining_q;
		stale_d    = stale_q;
		empty_d    = empty_q;
		written_d  = written_q;
		events_d   = events_q;
		charge     = 1'b0;
		unique case (op_t'(opcode))
			OP_FEED: begin
				if (!watching_q) begin
					written_d = '0;
					empty_d   = now_ext + (stale_q ? ring_us : '0);
					stale_d   = 1'b0;
				end
				draining_d = 1'b0;
				watching_d = 1'b1;
			end
			OP_WAIT: begin
				watching_d = 1'b0;
			end
			OP_DRAIN: begin
				draining_d = 1'b1;
				watching_d = 1'b0;
			end
			OP_FLUSHED: begin
				watching_d = 1'b0;
				stale_d    = 1'b1;
			end
			OP_RESERVE: begin
				charge = watching_q && !draining_q && sgt(empty_q, '0) &&
					(written_q >= CNT_W'(ring_length_ms)) && sgt(now_ext, empty_q);
				if (charge) begin
					events_d = sat_add(events_q, CNT_W'(1));
				end
				empty_d   = (sgt(now_ext, empty_q) ? now_ext : empty_q) + dur_us;
				written_d = sat_add(written_q, CNT_W'(duration_ms));
			end
			OP_ROLLBACK: begin
				empty_d = empty_q - dur_us;
				if (written_q >= CNT_W'(duration_ms)) begin
					written_d = written_q - CNT_W'(duration_ms);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watching_q <= 1'b0;
			draining_q <= 1'b0;
			stale_q    <= 1'b0;
			empty_q    <= '0;
			written_q  <= '0;
			events_q   <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				watching_q <= watching_d;
				draining_q <= draining_d;
				stale_q    <= stale_d;
				empty_q    <= empty_d;
				written_q  <= written_d;
				events_q   <= events_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1.watching <= watching_d;
			rec_s1.charge   <= charge;
			rec_s1.empty    <= empty_d;
			rec_s1.now      <= now_us;
			rec_s1.events   <= events_d;
			rec_s1.written  <= written_d;
			rec_s1.dividend <= charge ? gap[NOW_W-1:DIV_PRE_SHIFT] : '0;
		end
	end

	assign out_valid = valid_s1;
	assign out_rec   = rec_s1;

endmodule

/* rtl/core/arsl_div_step.sv */
// One pipelined long-division step: next 15-bit digit of (gap >> 3) over 125.
module arsl_div_step import arsl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_rec_t in_rec,
	output logic     out_valid,
	input  logic     out_ready,
	output div_rec_t out_rec
);

	logic [STEP_W-1:0]  v, r_est, r;
	logic [PROD_W-1:0]  prod;
	logic [CHUNK_W-1:0] q_est, q;
	logic               fix;
	div_rec_t           nxt;
	logic               valid_q;
	div_rec_t           rec_q;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		v     = {in_rec.rem, in_rec.dividend[DIV_W-1 -: CHUNK_W]};
		prod  = PROD_W'(v) * PROD_W'(DIV_K);
		q_est = prod[DIV_K_SHIFT +: CHUNK_W];
		// 125 * q = 128 * q - 3 * q
		r_est = v - (STEP_W'(q_est) << 7) + (STEP_W'(q_est) << 1) + STEP_W'(q_est);
		fix   = r_est >= STEP_W'(DIVISOR);
		q     = q_est + CHUNK_W'(fix);
		r     = fix ? r_est - STEP_W'(DIVISOR) : r_est;
		nxt          = in_rec;
		nxt.rem      = r[REM_W-1:0];
		nxt.dividend = in_rec.dividend << CHUNK_W;
		nxt.quot     = {in_rec.quot[DIV_W-CHUNK_W-1:0], q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rec_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

/* rtl/core/arsl_accum.sv */
// Starvation total accumulator and result register.
`include "audio_ring_starvation_ledger_macros.svh"
module arsl_accum import arsl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  div_rec_t         in_rec,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             speaker_playing,
	output logic [OUT_W-1:0] starved_total_ms,
	output logic [OUT_W-1:0] starve_count,
	output logic [OUT_W-1:0] written_total_ms
);

	logic [CNT_W-1:0] starved_q, starved_d;
	logic             valid_q, playing_q;
	logic [OUT_W-1:0] starved_out_q, count_q, written_q;
	logic             accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !valid_q || out_ready;
	assign starved_d = in_rec.charge ? sat_add(starved_q, CNT_W'(in_rec.quot)) : starved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			starved_q <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (accept) begin
				starved_q <= starved_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			playing_q     <= in_rec.playing;
			starved_out_q <= OUT_W'(starved_d);
			count_q       <= OUT_W'(in_rec.events);
			written_q     <= OUT_W'(in_rec.written);
		end
	end

	assign out_valid        = valid_q;
	assign speaker_playing  = playing_q;
	assign starved_total_ms = starved_out_q;
	assign starve_count     = count_q;
	assign written_total_ms = written_q;

	`ARSL_ASSERT_NEXT(a_starved_monotonic, 1'b1, starved_q >= $past(starved_q), "starved total went down")
	`ARSL_ASSERT_NEXT(a_no_charge_hold, accept && !in_rec.charge, $stable(starved_q), "starved total moved without a charge")
	`ARSL_ASSERT_NEXT(a_accept_shows, accept, valid_q && (starved_out_q == OUT_W'(starved_q)), "result register out of step with total")
	`ARSL_ASSERT_NOW(a_charge_needs_event, accept && in_rec.charge, in_rec.events != '0, "charge without a starvation event")

endmodule

/* rtl/core/audio_ring_starvation_ledger.sv */
// Top level of the audio ring starvation ledger.
// Usage:
//   Config: write ring_length_ms (index 0) or hold_window_ms (index 1) with
//   cfg_wr_en high for one cycle; take effect at once. The user must write
//   only while idle; the block itself does not enforce it. Input: opcode,
//   now_us, duration_ms move as one word on in_valid/in_ready. Output:
//   speaker_playing and the three 32-bit saturating metrics move as one
//   word on out_valid/out_ready, one result word per input word, in order.
//   Path: state update register, four division digit stages, result register.
//   Throughput: one word per cycle unless out_ready stalls; the gap-over-1000
//   divide runs as a four-stage pipeline. Stall: each stage holds its word
//   while the next is full and stalled, so input keeps flowing until all six
//   stages are occupied, then in_ready drops. Reset: arst_n clears flags,
//   empty time, counters, registers and pipeline.
module audio_ring_starvation_ledger import arsl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MS_W-1:0]      cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           opcode,
	input  logic [NOW_W-1:0]     now_us,
	input  logic [MS_W-1:0]      duration_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 speaker_playing,
	output logic [OUT_W-1:0]     starved_total_ms,
	output logic [OUT_W-1:0]     starve_count,
	output logic [OUT_W-1:0]     written_total_ms
);

	logic [MS_W-1:0]   ring_q, hold_q;
	logic              s1_valid, s1_ready;
	state_rec_t        s1_rec;
	logic              div_valid [DIV_STEPS+1];
	logic              div_ready [DIV_STEPS+1];
	div_rec_t          div_rec   [DIV_STEPS+1];
	logic [TIME_W-1:0] hold_us;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			hold_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RING_LENGTH: ring_q <= cfg_wdata;
				CFG_HOLD_WINDOW: hold_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	arsl_state u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.ring_length_ms (ring_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.now_us         (now_us),
		.duration_ms    (duration_ms),
		.out_valid      (s1_valid),
		.out_ready      (s1_ready),
		.out_rec        (s1_rec)
	);

	assign hold_us = TIME_W'(ms_to_us(hold_q));

	always_comb begin
		div_rec[0].playing  = s1_rec.watching &&
			sgt(s1_rec.empty + hold_us, {1'b0, s1_rec.now});
		div_rec[0].charge   = s1_rec.charge;
		div_rec[0].events   = s1_rec.events;
		div_rec[0].written  = s1_rec.written;
		div_rec[0].rem      = '0;
		div_rec[0].dividend = s1_rec.dividend;
		div_rec[0].quot     = '0;
	end

	assign div_valid[0] = s1_valid;
	assign s1_ready     = div_ready[0];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		arsl_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[g]),
			.in_ready  (div_ready[g]),
			.in_rec    (div_rec[g]),
			.out_valid (div_valid[g+1]),
			.out_ready (div_ready[g+1]),
			.out_rec   (div_rec[g+1])
		);
	end

	arsl_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (div_valid[DIV_STEPS]),
		.in_ready         (div_ready[DIV_STEPS]),
		.in_rec           (div_rec[DIV_STEPS]),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.speaker_playing  (speaker_playing),
		.starved_total_ms (starved_total_ms),
		.starve_count     (starve_count),
		.written_total_ms (written_total_ms)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the audio ring starvation ledger: directed and random events
`timescale 1ns / 100ps

module tb_top;
	import arsl_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_WORDS = 95;
	localparam int MAX_REPORTS = 10;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [NOW_W-1:0] NOW_MAX = '1;

	typedef struct packed {
		logic [2:0]       op;
		logic [NOW_W-1:0] now;
		logic [MS_W-1:0]  ms;
	} ring_event_t;

	typedef struct packed {
		logic             playing;
		logic [OUT_W-1:0] starved;
		logic [OUT_W-1:0] count;
		logic [OUT_W-1:0] written;
	} ledger_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MS_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	ring_event_t bus_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic speaker_playing;
	logic [OUT_W-1:0] starved_total_ms;
	logic [OUT_W-1:0] starve_count;
	logic [OUT_W-1:0] written_total_ms;

	audio_ring_starvation_ledger uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (bus_word.op),
		.now_us           (bus_word.now),
		.duration_ms      (bus_word.ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.speaker_playing  (speaker_playing),
		.starved_total_ms (starved_total_ms),
		.starve_count     (starve_count),
		.written_total_ms (written_total_ms)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	ring_event_t pending_words[$];
	ledger_result_t awaited_results[$];

	logic [MS_W-1:0] cfg_ring_ms = '0;
	logic [MS_W-1:0] cfg_hold_ms = '0;

	logic lg_watching = 1'b0;
	logic lg_draining = 1'b0;
	logic lg_stale = 1'b0;
	logic [63:0] lg_empty = '0;
	logic [OUT_W-1:0] lg_written = '0;
	logic [OUT_W-1:0] lg_starved = '0;
	logic [OUT_W-1:0] lg_starve_events = '0;

	logic [NOW_W-1:0] stim_now = '0;
	logic in_fire = 1'b0;
	int cycle_count = 0;
	int fail_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int charges_predicted = 0;
	int settings_applied = 0;
	int queued_words = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_left = 0;
	int rx_tick = 0;
	int rx_mode = 0;

	function automatic logic [OUT_W-1:0] clamp_add(input logic [OUT_W-1:0] a,
			input logic [OUT_W-1:0] b);
		return (b > ~a) ? {OUT_W{1'b1}} : a + b;
	endfunction

	task automatic advance_ledger(input ring_event_t ev, output ledger_result_t res);
		logic [63:0] now64;
		logic [63:0] dur_us;
		logic [63:0] gap_ms;
		logic [63:0] base;
		now64 = {1'b0, ev.now};
		dur_us = 64'(ev.ms) * 64'(US_PER_MS);
		case (ev.op)
			OP_FEED: begin
				if (!lg_watching) begin
					lg_written = '0;
					lg_empty = now64 + (lg_stale ? 64'(cfg_ring_ms) * 64'(US_PER_MS) : 64'd0);
					lg_stale = 1'b0;
				end
				lg_draining = 1'b0;
				lg_watching = 1'b1;
			end
			OP_WAIT: lg_watching = 1'b0;
			OP_DRAIN: begin
				lg_draining = 1'b1;
				lg_watching = 1'b0;
			end
			OP_FLUSHED: begin
				lg_watching = 1'b0;
				lg_stale = 1'b1;
			end
			OP_RESERVE: begin
				if (lg_watching && !lg_draining && $signed(lg_empty) > 64'sd0 &&
						lg_written >= OUT_W'(cfg_ring_ms) &&
						$signed(now64) > $signed(lg_empty)) begin
					gap_ms = (now64 - lg_empty) / 64'(US_PER_MS);
					lg_starved = clamp_add(lg_starved, gap_ms[OUT_W-1:0]);
					lg_starve_events = clamp_add(lg_starve_events, OUT_W'(1));
					charges_predicted++;
				end
				base = ($signed(now64) > $signed(lg_empty)) ? now64 : lg_empty;
				lg_empty = base + dur_us;
				lg_written = clamp_add(lg_written, OUT_W'(ev.ms));
			end
			OP_ROLLBACK: begin
				lg_empty = lg_empty - dur_us;
				if (lg_written >= OUT_W'(ev.ms))
					lg_written = lg_written - OUT_W'(ev.ms);
			end
			default: ;
		endcase
		res.playing = lg_watching &&
			($signed(lg_empty + 64'(cfg_hold_ms) * 64'(US_PER_MS)) > $signed(now64));
		res.starved = lg_starved;
		res.count = lg_starve_events;
		res.written = lg_written;
	endtask

	// check the oldest expectation first, then predict for the word taken at this edge
	always @(posedge clk) begin : monitor
		ledger_result_t seen;
		ledger_result_t want;
		ledger_result_t fresh;
		seen = {speaker_playing, starved_total_ms, starve_count, written_total_ms};
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result at cycle %0d: playing %0b starved %0d count %0d written %0d",
						cycle_count, seen.playing, seen.starved, seen.count, seen.written);
			end else begin
				want = awaited_results.pop_front();
				if (seen !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("result %0d differs (exp/got): playing %0b/%0b starved %0d/%0d count %0d/%0d written %0d/%0d",
							results_checked, want.playing, seen.playing, want.starved, seen.starved,
							want.count, seen.count, want.written, seen.written);
				end
				results_checked++;
			end
		end
		if (arst_n && in_valid && in_ready) begin
			advance_ledger(bus_word, fresh);
			awaited_results.push_back(fresh);
			words_sent++;
		end
		in_fire <= arst_n && in_valid && in_ready;
	end

	// send in bursts; hold the word until it is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				bus_word <= pending_words.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1)
					burst_left--;
				else begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 2) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(7, 30);
					else
						gap_left = $urandom_range(1, 6);
				end
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver backpressure, in one of four patterns that rx_mode picks at random
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ((rx_tick % 5) != 4);
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(1, 20);
						out_ready <= 1'b0;
					end else
						out_ready <= 1'b1;
				end
			endcase
		end
		rx_tick++;
		if (rx_tick % 256 == 0)
			rx_mode = $urandom_range(0, 3);
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("run stopped at cycle %0d with %0d results outstanding",
			cycle_count, awaited_results.size());
		$display("FAILED: results differ");
		$finish;
	end

	task automatic queue_word(input logic [2:0] op, input logic [NOW_W-1:0] now,
			input logic [MS_W-1:0] ms);
		pending_words.push_back('{op: op, now: now, ms: ms});
		queued_words++;
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == CFG_RING_LENGTH)
			cfg_ring_ms = value;
		else
			cfg_hold_ms = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_settings(input logic [MS_W-1:0] ring_ms, input logic [MS_W-1:0] hold_ms);
		wait_drained();
		write_register(CFG_RING_LENGTH, ring_ms);
		write_register(CFG_HOLD_WINDOW, hold_ms);
		settings_applied++;
	endtask

	task automatic queue_noise(input logic wide);
		logic [NOW_W-1:0] now;
		if (wide)
			now = NOW_W'({$urandom, $urandom});
		else
			now = stim_now + NOW_W'($urandom_range(0, 1000000));
		queue_word(3'($urandom_range(0, 7)), now, MS_W'($urandom));
	endtask

	// usually arm, reserve ahead of or behind the empty time among other ops, then disarm
	task automatic queue_session();
		int steps;
		int pick;
		int unsigned ms_cap;
		logic [MS_W-1:0] last_ms;
		ms_cap = cfg_ring_ms / 3 + 64;
		last_ms = '0;
		if ($urandom_range(0, 5) == 0)
			stim_now = NOW_MAX - NOW_W'($urandom_range(0, 200000000));
		else
			stim_now += NOW_W'($urandom_range(0, 5000000));
		if ($urandom_range(0, 7) != 0)
			queue_word(OP_FEED, stim_now, MS_W'($urandom));
		steps = $urandom_range(4, 24);
		repeat (steps) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 9) == 0)
					last_ms = MS_W'($urandom);
				else
					last_ms = MS_W'($urandom_range(0, ms_cap));
				stim_now += NOW_W'($urandom_range(0, last_ms * 2200 + 3000));
				queue_word(OP_RESERVE, stim_now, last_ms);
			end else if (pick < 78)
				queue_word(OP_ROLLBACK, stim_now,
					($urandom_range(0, 2) == 0) ? MS_W'($urandom) : last_ms);
			else if (pick < 86)
				queue_word(OP_QUERY, stim_now + NOW_W'($urandom_range(0, 70000000)),
					MS_W'($urandom));
			else if (pick < 90)
				queue_word(OP_WAIT, stim_now, MS_W'($urandom));
			else if (pick < 93)
				queue_word(OP_DRAIN, stim_now, MS_W'($urandom));
			else if (pick < 96)
				queue_word(OP_FLUSHED, stim_now, MS_W'($urandom));
			else
				queue_word(OP_FEED, stim_now, MS_W'($urandom));
		end
		case ($urandom_range(0, 2))
			0: queue_word(OP_WAIT, stim_now, MS_W'($urandom));
			1: queue_word(OP_DRAIN, stim_now, MS_W'($urandom));
			default: queue_word(OP_FLUSHED, stim_now, MS_W'($urandom));
		endcase
	endtask

	task automatic queue_random_phase(input int target, input logic wide);
		int start;
		start = queued_words;
		while (queued_words - start < target) begin
			if ($urandom_range(0, 9) == 0)
				queue_noise(wide);
			else
				queue_session();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apply_settings(16'd0, 16'd0);
		queue_word(OP_QUERY, '0, '0);
		queue_word(OP_QUERY, NOW_MAX, 16'hFFFF);
		queue_word(OP_RESERVE, 63'd5000, 16'd3);
		queue_word(OP_ROLLBACK, '0, 16'd5);
		queue_word(OP_FEED, 63'd1000, 16'd0);
		queue_word(OP_FEED, 63'd2000, 16'd0);
		queue_word(OP_RESERVE, 63'd1000, 16'd0);
		queue_word(OP_RESERVE, 63'd4294967304000, 16'd2);
		queue_word(OP_UNUSED, 63'd4294967304000, 16'h5A5A);
		queue_word(OP_WAIT, '0, 16'd0);
		queue_word(OP_FEED, NOW_MAX, 16'd0);
		queue_word(OP_RESERVE, NOW_MAX, 16'hFFFF);
		queue_word(OP_QUERY, NOW_MAX, 16'd0);
		queue_word(OP_ROLLBACK, NOW_MAX, 16'hFFFF);
		queue_word(OP_DRAIN, '0, 16'd0);
		queue_word(OP_FLUSHED, '0, 16'd0);

		apply_settings(16'd100, 16'hFFFF);
		queue_word(OP_FEED, 63'd10000, 16'd0);
		queue_word(OP_QUERY, 63'd50000, 16'd0);
		queue_word(OP_RESERVE, 63'd20000, 16'd150);
		queue_word(OP_RESERVE, 63'd500000, 16'd1);
		queue_word(OP_ROLLBACK, '0, 16'd200);
		queue_word(OP_RESERVE, 63'd301999, 16'd0);
		queue_word(OP_QUERY, 63'd400000000, 16'd0);
		queue_word(OP_DRAIN, '0, 16'd0);
		queue_word(OP_RESERVE, 63'd600000000, 16'd7);

		apply_settings(16'hFFFF, 16'd0);
		queue_random_phase(PHASE_WORDS, 1'b0);
		apply_settings(MS_W'($urandom), MS_W'($urandom));
		queue_random_phase(PHASE_WORDS, 1'b0);
		apply_settings(16'd20, 16'd5);
		queue_random_phase(PHASE_WORDS, 1'b0);
		apply_settings(16'd0, 16'hFFFF);
		queue_random_phase(PHASE_WORDS, 1'b0);
		apply_settings(MS_W'($urandom_range(0, 2000)), MS_W'($urandom_range(0, 2000)));
		queue_random_phase(PHASE_WORDS, 1'b0);
		apply_settings(MS_W'($urandom), MS_W'($urandom));
		queue_random_phase(PHASE_WORDS, 1'b1);

		// drive the starvation total into saturation
		apply_settings(16'd0, 16'd0);
		queue_word(OP_WAIT, '0, 16'd0);
		queue_word(OP_FEED, 63'd1000, 16'd0);
		queue_word(OP_RESERVE, 63'd4294967296000, 16'd0);
		queue_word(OP_RESERVE, 63'd4294967301000, 16'd0);
		queue_word(OP_QUERY, 63'd4294967301000, 16'd0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d event words sent under %0d register settings, %0d results checked",
			words_sent, settings_applied, results_checked);
		$display("%0d starvation charges predicted, %0d failures", charges_predicted, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
